// File: design/bitmap_first_fit_allocator_core_defines.svh
// assertion macros used by the allocator core
// expects signals named clock and reset in the including module
`ifndef BITMAP_FIRST_FIT_ALLOCATOR_CORE_DEFINES_SVH
`define BITMAP_FIRST_FIT_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BFFA_CHECK(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define BFFA_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/bffa_pkg.sv
// types, sizes and codes of the bitmap first-fit allocator
// no dependencies
package bffa_pkg;

   localparam int MAX_BITS   = 1024;
   localparam int WORD_BITS  = 64;
   localparam int BIT_W      = $clog2(WORD_BITS);
   localparam int WORD_COUNT = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_AW    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int IDX_W      = 10;
   localparam int CNT_W      = 11;
   localparam logic [CNT_W-1:0] MAX_TOTAL = CNT_W'(MAX_BITS);
   localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
   localparam logic [CNT_W-1:0] CSR_RESET = CNT_W'(1024);

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_QUERY = 2'd2,
      OP_CLEAR = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NO_FREE   = 2'd1,
      STATUS_BAD_INDEX = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOKUP,
      S_COMMIT
   } state_type;

   typedef struct packed {
      opcode_type       opcode;
      logic [IDX_W-1:0] bit_index;
   } req_type;

   typedef struct packed {
      status_type       status;
      logic [IDX_W-1:0] granted_index;
      logic             is_set;
      logic [CNT_W-1:0] free_count;
   } rsp_type;

   typedef struct packed {
      logic                 rd_en;
      logic [WORD_AW-1:0]   rd_addr;
      logic                 wr_en;
      logic [WORD_AW-1:0]   wr_addr;
      logic [WORD_BITS-1:0] wr_data;
      logic                 wipe;
   } store_cmd_type;

endpackage

// File: design/bffa_word_store.sv
// usage bitmap store: synchronous word memory with registered read data and per-word
// written and full flags; depends on bffa_pkg
module bffa_word_store
   import bffa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  store_cmd_type         cmd,
   output logic [WORD_BITS-1:0]  rd_data,
   output logic [WORD_COUNT-1:0] nonfull
);

   logic [WORD_BITS-1:0]  mem [WORD_COUNT];
   logic [WORD_BITS-1:0]  rd_data_ff;
   logic                  rd_written_ff;
   logic [WORD_COUNT-1:0] written_ff;
   logic [WORD_COUNT-1:0] full_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff    <= mem[cmd.rd_addr];
         rd_written_ff <= written_ff[cmd.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.wipe) begin
         written_ff <= '0;
         full_ff    <= '0;
      end else if (cmd.wr_en) begin
         written_ff[cmd.wr_addr] <= 1'b1;
         full_ff[cmd.wr_addr]    <= &cmd.wr_data;
      end
   end

   // words never written since the last clear read as empty
   assign rd_data = rd_written_ff ? rd_data_ff : '0;
   assign nonfull = ~full_ff;

endmodule

// File: design/bffa_find.sv
// lowest-set finders for the word summary and for the free bits of one word
// depends on bffa_pkg
module bffa_find
   import bffa_pkg::*;
(
   input  logic [WORD_COUNT-1:0] word_vec,
   input  logic [WORD_BITS-1:0]  bit_vec,
   output logic                  word_any,
   output logic [WORD_AW-1:0]    word_sel,
   output logic                  bit_any,
   output logic [BIT_W-1:0]      bit_sel
);

   always_comb begin
      word_any = |word_vec;
      word_sel = '0;
      for (int i = WORD_COUNT - 1; i >= 0; i--) begin
         if (word_vec[i]) begin
            word_sel = WORD_AW'(i);
         end
      end
   end

   always_comb begin
      bit_any = |bit_vec;
      bit_sel = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (bit_vec[i]) begin
            bit_sel = BIT_W'(i);
         end
      end
   end

endmodule

// File: design/bitmap_first_fit_allocator_core.sv
// flow: an accepted request beat passes through word lookup and commit before its
// response beat is registered; commit waits while rsp_stall holds a response beat
// no request is taken until the last one commits, for a store word read-modify-write
// reset: bitmap empties at once through per-word flags, free count and capacity csr
// return to 1024, no clearing pass
`include "bitmap_first_fit_allocator_core_defines.svh"

module bitmap_first_fit_allocator_core
   import bffa_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_wr_en,
   input  logic [CNT_W-1:0] csr_wr_data
);

   state_type            state_ff, state_in;
   req_type              req_ff, req_in;
   logic [WORD_AW-1:0]   addr_ff, addr_in;
   logic                 any_ff, any_in;
   rsp_type              pend_ff, pend_in;
   logic                 wr_ff, wr_in;
   logic                 clr_ff, clr_in;
   logic [WORD_BITS-1:0] wdata_ff, wdata_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     csr_ff;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   store_cmd_type         store_cmd;
   logic [WORD_BITS-1:0]  word;
   logic [WORD_COUNT-1:0] nonfull;
   logic                  word_any;
   logic [WORD_AW-1:0]    word_sel;
   logic                  zero_any;
   logic [BIT_W-1:0]      zero_sel;
   logic [CNT_W-1:0]      eff_total;
   logic [CNT_W-1:0]      cand;
   logic                  idx_ok;
   logic                  bit_val;
   logic                  accept;
   logic                  commit_go;

   bffa_word_store u_store (
      .clock   (clock),
      .reset   (reset),
      .cmd     (store_cmd),
      .rd_data (word),
      .nonfull (nonfull)
   );

   bffa_find u_find (
      .word_vec (nonfull),
      .bit_vec  (~word),
      .word_any (word_any),
      .word_sel (word_sel),
      .bit_any  (zero_any),
      .bit_sel  (zero_sel)
   );

   assign eff_total = (csr_ff > MAX_TOTAL) ? MAX_TOTAL : csr_ff;
   assign cand      = CNT_W'({addr_ff, zero_sel});
   assign idx_ok    = CNT_W'(req_ff.bit_index) < eff_total;
   assign bit_val   = word[req_ff.bit_index[BIT_W-1:0]];
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign commit_go = (state_ff == S_COMMIT) && !(rsp_valid_ff && rsp_stall);

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      addr_in      = addr_ff;
      any_in       = any_ff;
      pend_in      = pend_ff;
      wr_in        = wr_ff;
      clr_in       = clr_ff;
      wdata_in     = wdata_ff;
      count_in     = count_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      store_cmd.rd_en     = accept;
      store_cmd.rd_addr   = (req_data.opcode == OP_ALLOC) ? word_sel
                                                          : req_data.bit_index[BIT_W +: WORD_AW];
      store_cmd.wr_en     = commit_go && wr_ff;
      store_cmd.wr_addr   = addr_ff;
      store_cmd.wr_data   = wdata_ff;
      store_cmd.wipe      = commit_go && clr_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in   = req_data;
               addr_in  = store_cmd.rd_addr;
               any_in   = word_any;
               state_in = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            pend_in.status        = STATUS_OK;
            pend_in.granted_index = '0;
            pend_in.is_set        = 1'b0;
            pend_in.free_count    = count_ff;
            wr_in    = 1'b0;
            clr_in   = 1'b0;
            wdata_in = word;
            case (req_ff.opcode)
               OP_ALLOC: begin
                  if ((count_ff != '0) && any_ff && zero_any && (cand < eff_total)) begin
                     pend_in.granted_index = IDX_W'(cand);
                     pend_in.free_count    = count_ff - CNT_W'(1);
                     wdata_in[zero_sel]    = 1'b1;
                     wr_in                 = 1'b1;
                  end else begin
                     pend_in.status = STATUS_NO_FREE;
                  end
               end
               OP_FREE: begin
                  if (!idx_ok) begin
                     pend_in.status = STATUS_BAD_INDEX;
                  end else if (bit_val) begin
                     wdata_in[req_ff.bit_index[BIT_W-1:0]] = 1'b0;
                     wr_in = 1'b1;
                     if (count_ff != COUNT_MAX) begin
                        pend_in.free_count = count_ff + CNT_W'(1);
                     end
                  end
               end
               OP_QUERY: begin
                  if (!idx_ok) begin
                     pend_in.status = STATUS_BAD_INDEX;
                  end else begin
                     pend_in.is_set = bit_val;
                  end
               end
               default: begin
                  clr_in             = 1'b1;
                  pend_in.free_count = eff_total;
               end
            endcase
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (commit_go) begin
               count_in     = pend_ff.free_count;
               rsp_in       = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= CSR_RESET;
         csr_ff       <= CSR_RESET;
         wr_ff        <= 1'b0;
         clr_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         wr_ff        <= wr_in;
         clr_ff       <= clr_in;
         if (csr_wr_en) begin
            csr_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      addr_ff  <= addr_in;
      any_ff   <= any_in;
      pend_ff  <= pend_in;
      wdata_ff <= wdata_in;
      rsp_ff   <= rsp_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `BFFA_CHECK(a_count_bound, 1'b1, count_ff <= MAX_TOTAL, "free count above capacity")
   `BFFA_CHECK_NEXT(a_lookup_then_commit, state_ff == S_LOOKUP, state_ff == S_COMMIT,
      "lookup not followed by commit")
   `BFFA_CHECK(a_grant_in_range,
      (state_ff == S_COMMIT) && (req_ff.opcode == OP_ALLOC) && (pend_ff.status == STATUS_OK),
      CNT_W'(pend_ff.granted_index) < eff_total, "grant beyond total")
   `BFFA_CHECK(a_store_write_in_commit, store_cmd.wr_en || store_cmd.wipe,
      state_ff == S_COMMIT, "store written outside commit")

endmodule

// File: tb/sv/bffa_alloc_checker.sv
// checker for the bitmap first-fit allocator: watches request, response and csr ports,
// keeps its own usage bitmap and free count, and compares every response beat
// depends on bffa_pkg
`timescale 1ns / 1ps

module bffa_alloc_checker
   import bffa_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  req_type          req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  rsp_type          rsp_data,
   input  logic             csr_wr_en,
   input  logic [CNT_W-1:0] csr_wr_data,
   output int               errors,
   output int               pending,
   output int               checked
);

   logic [MAX_BITS-1:0] taken;
   logic [CNT_W-1:0]    free_left;
   logic [CNT_W-1:0]    capacity;
   rsp_type             owed_rsps[$];

   function automatic logic [CNT_W-1:0] usable_bits();
      return (capacity > MAX_TOTAL) ? MAX_TOTAL : capacity;
   endfunction

   function automatic rsp_type apply_request(req_type rq);
      rsp_type          rs;
      logic [CNT_W-1:0] lim;
      bit               found;
      int               hit;
      lim = usable_bits();
      rs = '0;
      rs.status = STATUS_OK;
      found = 1'b0;
      hit = 0;
      case (rq.opcode)
         OP_ALLOC: begin
            if (free_left != 0) begin
               for (int b = 0; b < int'(lim); b++) begin
                  if (!found && !taken[b]) begin
                     found = 1'b1;
                     hit = b;
                  end
               end
            end
            if (found) begin
               taken[hit] = 1'b1;
               free_left = free_left - 1'b1;
               rs.granted_index = IDX_W'(hit);
            end else begin
               rs.status = STATUS_NO_FREE;
            end
         end
         OP_FREE: begin
            if ({1'b0, rq.bit_index} >= lim) begin
               rs.status = STATUS_BAD_INDEX;
            end else if (taken[rq.bit_index]) begin
               taken[rq.bit_index] = 1'b0;
               if (free_left != COUNT_MAX) free_left = free_left + 1'b1;
            end
         end
         OP_QUERY: begin
            if ({1'b0, rq.bit_index} >= lim) rs.status = STATUS_BAD_INDEX;
            else rs.is_set = taken[rq.bit_index];
         end
         default: begin
            taken = '0;
            free_left = lim;
         end
      endcase
      rs.free_count = free_left;
      return rs;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         taken = '0;
         capacity = CSR_RESET;
         free_left = MAX_TOTAL;
         owed_rsps.delete();
      end else begin
         if (csr_wr_en) capacity = csr_wr_data;
         if (rsp_valid && !rsp_stall) begin
            if (owed_rsps.size() == 0) begin
               $error("response beat with no request outstanding");
               errors++;
            end else begin
               want = owed_rsps.pop_front();
               checked++;
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  errors++;
               end
               if (rsp_data.granted_index !== want.granted_index) begin
                  $error("granted_index: expected %0d, got %0d",
                         want.granted_index, rsp_data.granted_index);
                  errors++;
               end
               if (rsp_data.is_set !== want.is_set) begin
                  $error("is_set: expected %0d, got %0d", want.is_set, rsp_data.is_set);
                  errors++;
               end
               if (rsp_data.free_count !== want.free_count) begin
                  $error("free_count: expected %0d, got %0d",
                         want.free_count, rsp_data.free_count);
                  errors++;
               end
            end
         end
         if (req_valid && !req_stall) owed_rsps.push_back(apply_request(req_data));
      end
      pending = owed_rsps.size();
   end

endmodule

// File: tb/sv/tb.sv
// top of the allocator testbench: clock, reset, request and csr stimulus, response
// stalls, watchdog and verdict
// depends on bffa_pkg, bitmap_first_fit_allocator_core and bffa_alloc_checker
`timescale 1ns / 1ps

module tb;
   import bffa_pkg::*;

   localparam int QUIET_LIMIT = 3000;
   localparam int ITEM_GOAL   = 1900;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   req_type          req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   rsp_type          rsp_data;
   logic             csr_wr_en;
   logic [CNT_W-1:0] csr_wr_data;

   int errors;
   int pending;
   int checked;
   int sent;
   int writes;
   bit squeeze_on;

   bitmap_first_fit_allocator_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   bffa_alloc_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .errors      (errors),
      .pending     (pending),
      .checked     (checked)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // mostly zero or short, now and then long
   function automatic int pause_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [IDX_W-1:0] pick_index(logic [CNT_W-1:0] cap);
      int lim;
      lim = (cap > MAX_TOTAL) ? MAX_BITS : int'(cap);
      if (lim > 0 && $urandom_range(0, 99) < 80)
         return IDX_W'($urandom_range(0, (lim < MAX_BITS) ? lim : MAX_BITS - 1));
      return IDX_W'($urandom);
   endfunction

   task automatic send_req(opcode_type op, logic [IDX_W-1:0] idx);
      req_type beat;
      int      gap;
      gap = pause_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      beat.opcode = op;
      beat.bit_index = idx;
      req_data <= beat;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic set_capacity(logic [CNT_W-1:0] cap);
      settle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= cap;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      writes++;
   endtask

   task automatic random_phase(logic [CNT_W-1:0] cap, bit wipe, int n, int alloc_pct,
                               int clear_pct);
      opcode_type op;
      int         r;
      set_capacity(cap);
      if (wipe) send_req(OP_CLEAR, IDX_W'($urandom));
      repeat (n) begin
         r = $urandom_range(0, 99);
         if (r < alloc_pct) op = OP_ALLOC;
         else if (r < alloc_pct + clear_pct) op = OP_CLEAR;
         else if ($urandom_range(0, 99) < 60) op = OP_FREE;
         else op = OP_QUERY;
         send_req(op, pick_index(cap));
      end
   endtask

   function automatic logic [CNT_W-1:0] pick_capacity();
      logic [CNT_W-1:0] marks [16];
      int r;
      marks = '{11'd0, 11'd1, 11'd2, 11'd3, 11'd7, 11'd8, 11'd9, 11'd63, 11'd64, 11'd65,
                11'd127, 11'd128, 11'd1023, 11'd1024, 11'd1025, 11'd2047};
      r = $urandom_range(0, 99);
      if (r < 45) return marks[$urandom_range(0, 15)];
      if (r < 90) return CNT_W'($urandom_range(1, 200));
      return CNT_W'($urandom_range(0, 2047));
   endfunction

   initial begin : rsp_side
      int  len;
      bit  squeezed;
      logic hold;
      squeezed = 1'b0;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         if (squeeze_on && !squeezed) begin
            // long back-pressure so the block fills and stalls its input
            squeezed = 1'b1;
            hold = 1'b1;
            len = 400;
         end else begin
            len = pause_len();
            hold = (len > 0);
            if (len == 0) len = $urandom_range(1, 40);
         end
         rsp_stall <= hold;
         repeat (len) @(negedge clock);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("tb NOT OK");
      $finish;
   end

   initial begin : stimulus
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      squeeze_on = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // default capacity of 1024 right after reset
      send_req(OP_QUERY, 10'd0);
      send_req(OP_ALLOC, 10'd0);
      send_req(OP_ALLOC, 10'd1023);
      send_req(OP_QUERY, 10'd1);
      send_req(OP_QUERY, 10'd1023);
      send_req(OP_FREE, 10'd1);
      send_req(OP_FREE, 10'd1);
      send_req(OP_FREE, 10'd1023);
      send_req(OP_ALLOC, 10'd0);
      send_req(OP_CLEAR, 10'd1023);
      // shrink without a wipe, then wipe
      set_capacity(11'd8);
      send_req(OP_QUERY, 10'd8);
      send_req(OP_FREE, 10'd1023);
      send_req(OP_CLEAR, 10'd0);
      // capacity above the store saturates
      set_capacity(11'd2047);
      send_req(OP_CLEAR, 10'd0);
      send_req(OP_QUERY, 10'd1023);
      // zero capacity
      set_capacity(11'd0);
      send_req(OP_ALLOC, 10'd0);
      send_req(OP_QUERY, 10'd0);
      send_req(OP_CLEAR, 10'd0);
      send_req(OP_ALLOC, 10'd0);
      // count reaches zero, then capacity grows without a wipe
      set_capacity(11'd4);
      send_req(OP_CLEAR, 10'd0);
      repeat (4) send_req(OP_ALLOC, 10'd0);
      set_capacity(11'd8);
      send_req(OP_ALLOC, 10'd0);
      send_req(OP_FREE, 10'd2);
      send_req(OP_ALLOC, 10'd0);
      send_req(OP_ALLOC, 10'd0);
      // search exhausts the range while the count is still nonzero
      set_capacity(11'd8);
      send_req(OP_CLEAR, 10'd0);
      set_capacity(11'd3);
      repeat (4) send_req(OP_ALLOC, 10'd0);

      // deep fill of the full store under heavy back-pressure
      squeeze_on = 1'b1;
      random_phase(11'd1024, 1'b1, 650, 85, 0);
      while (sent < ITEM_GOAL)
         random_phase(pick_capacity(), ($urandom_range(0, 99) < 80),
                      $urandom_range(60, 160), 45, 4);

      settle();
      $display("%0d requests across %0d capacity writes (0 to 2047, with and without wipes)",
               sent, writes);
      $display("%0d response beats checked against the predicted bitmap", checked);
      if (errors == 0) $display("tb OK");
      else $display("tb NOT OK");
      $finish;
   end

endmodule

// File: bitmap_first_fit_allocator_core.f
+incdir+design
design/bffa_pkg.sv
design/bffa_word_store.sv
design/bffa_find.sv
design/bitmap_first_fit_allocator_core.sv
tb/sv/bffa_alloc_checker.sv
tb/sv/tb.sv
